// ===== rtl/core/integer_to_radix_digits_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the integer to radix digits block
// Shorthand for clocked implication properties, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_DIGITS_ASSERT_SVH
`define INTEGER_TO_RADIX_DIGITS_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ITRD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ITRD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/itrd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrd_pkg
// Shared types, constants and the symbol lookup for the radix digit block.
// ----------------------------------------------------------------------------
package itrd_pkg;

  localparam int VALUE_W     = 32;
  localparam int SYM_W       = 8;
  localparam int SIZE_W      = 5;
  localparam int SYM_IDX_W   = 4;
  localparam int NUM_SYMBOLS = 16;
  localparam int DIGIT_W     = 4;
  localparam int DEPTH       = 32;
  localparam int DEPTH_W     = 5;
  localparam int DIV_STEPS   = 8;
  localparam int DIV_CYCLES  = VALUE_W / DIV_STEPS;
  localparam int DIV_CNT_W   = 2;
  localparam int REG_W       = 64;
  localparam int ADDR_W      = 5;

  localparam logic [SIZE_W-1:0] MIN_RADIX = 5'd2;

  localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] SYM_NONE  = 8'h00;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_BAD_BASE = 1'b1;

  localparam logic [1:0] REG_BASE_SIZE    = 2'd0;
  localparam logic [1:0] REG_SYMBOLS_LOW  = 2'd1;
  localparam logic [1:0] REG_SYMBOLS_HIGH = 2'd2;

  localparam logic [SIZE_W-1:0] RST_BASE_SIZE    = 5'd10;
  localparam logic [REG_W-1:0]  RST_SYMBOLS_LOW  = 64'h3736_3534_3332_3130;
  localparam logic [REG_W-1:0]  RST_SYMBOLS_HIGH = 64'h0000_0000_0000_3938;

  typedef struct packed {
    logic done;
    logic ok;
  } chk_status_t;

  // Symbol k of the sixteen held in the two symbol registers.
  function automatic logic [SYM_W-1:0] symbol_at(input logic [REG_W-1:0] lo,
                                                 input logic [REG_W-1:0] hi,
                                                 input logic [SYM_IDX_W-1:0] k);
    logic [2*REG_W-1:0] all;
    all = {hi, lo};
    return all[{k, 3'b000} +: SYM_W];
  endfunction

endpackage

// ===== rtl/core/itrd_div_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrd_div_step
// Eight restoring division steps of a 32-bit quotient register by the radix.
// ----------------------------------------------------------------------------
module itrd_div_step (
  input  logic [itrd_pkg::DIGIT_W-1:0] rem_in,
  input  logic [itrd_pkg::VALUE_W-1:0] quo_in,
  input  logic [itrd_pkg::SIZE_W-1:0]  divisor,
  output logic [itrd_pkg::DIGIT_W-1:0] rem_out,
  output logic [itrd_pkg::VALUE_W-1:0] quo_out
);
  import itrd_pkg::*;

  logic [DIGIT_W-1:0] r;
  logic [VALUE_W-1:0] q;
  logic [DIGIT_W:0]   r5;
  logic               ge;

  // The dividend shifts out at the top while quotient bits shift in below,
  // so after four passes the register holds the quotient.
  always_comb begin
    r  = rem_in;
    q  = quo_in;
    r5 = '0;
    ge = 1'b0;
    for (int k = 0; k < DIV_STEPS; k++) begin
      r5 = {r, q[VALUE_W-1]};
      ge = (r5 >= divisor);
      q  = {q[VALUE_W-2:0], ge};
      r  = ge ? DIGIT_W'(r5 - divisor) : r5[DIGIT_W-1:0];
    end
    rem_out = r;
    quo_out = q;
  end

endmodule

// ===== rtl/core/itrd_base_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrd_base_check
// Walks the symbol list one entry a cycle and validates the configured base.
// ----------------------------------------------------------------------------
module itrd_base_check #(
  parameter int MAX_SYMBOLS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [itrd_pkg::SIZE_W-1:0] base_size,
  input  logic [itrd_pkg::REG_W-1:0]  symbols_low,
  input  logic [itrd_pkg::REG_W-1:0]  symbols_high,
  output itrd_pkg::chk_status_t       status
);
  import itrd_pkg::*;

  logic              running;
  logic [SIZE_W-1:0] idx;
  logic [SYM_W-1:0]  cur_sym;
  logic              size_bad;
  logic              sym_bad;

  assign size_bad = (base_size < MIN_RADIX) || (base_size > SIZE_W'(MAX_SYMBOLS));
  assign cur_sym  = symbol_at(symbols_low, symbols_high, idx[SYM_IDX_W-1:0]);

  // The current symbol against the sign bytes and every later symbol in use.
  always_comb begin
    sym_bad = (cur_sym == SYM_PLUS) || (cur_sym == SYM_MINUS);
    for (int j = 0; j < NUM_SYMBOLS; j++) begin
      if ((SIZE_W'(j) > idx) && (SIZE_W'(j) < base_size) &&
          (symbol_at(symbols_low, symbols_high, SYM_IDX_W'(j)) == cur_sym)) begin
        sym_bad = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running     <= 1'b0;
      status.done <= 1'b0;
      status.ok   <= 1'b0;
    end else begin
      status.done <= 1'b0;
      if (start) begin
        if (size_bad) begin
          status.done <= 1'b1;
          status.ok   <= 1'b0;
        end else begin
          running <= 1'b1;
          idx     <= '0;
        end
      end else if (running) begin
        if (idx == base_size) begin
          running     <= 1'b0;
          status.done <= 1'b1;
          status.ok   <= 1'b1;
        end else if (sym_bad) begin
          running     <= 1'b0;
          status.done <= 1'b1;
          status.ok   <= 1'b0;
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/integer_to_radix_digits.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_radix_digits
// Converts a signed 32-bit value to its text in a configurable radix.
// ----------------------------------------------------------------------------
// One value enters on the s_ channel; its text leaves on the m_ channel as a
// run of symbol bytes, most significant first, with tlast on the final byte.
// A negative value is preceded by a minus sign. When the configured base is
// invalid (fewer than two symbols, more than MAX_SYMBOLS, a repeated symbol,
// or a plus or minus symbol) a single transfer with symbol zero, tlast high
// and tuser high is sent instead of text.
// Sequence: the value is taken, the base is checked, then each digit that
// needs a division passes through one shared divide unit (it retires eight
// quotient bits a cycle) and the leading digit is written without one; each
// output byte then takes a digit stack read and a load of the output
// register, with a minus sign loaded first for a negative value. s_tready is
// high only while no value is in progress.
// The output register decouples the receiver: when m_tready is low the byte
// is held and the sequencer waits. Reset restores base 10 with symbols "0" to
// "9" and empties the output; the digit stack needs no clearing.
// Registers sit at byte addresses 0, 8 and 16 of the 64-bit APB-style port.
// ----------------------------------------------------------------------------
module integer_to_radix_digits #(
  parameter int MAX_SYMBOLS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] symbol
  output logic        m_tlast,
  output logic [0:0]  m_tuser,   // [0] status (1 = bad base)
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import itrd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_SIGN,
    S_READ,
    S_SEND,
    S_BAD
  } state_t;

  // Configuration registers
  logic [SIZE_W-1:0] base_size;
  logic [REG_W-1:0]  symbols_low;
  logic [REG_W-1:0]  symbols_high;
  logic              cfg_we;
  logic [1:0]        cfg_idx;

  // Sequencer state and working registers
  state_t               state;
  logic                 neg;
  logic [VALUE_W-1:0]   mag;
  logic [DIGIT_W-1:0]   div_rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 div_busy;
  logic [DEPTH_W-1:0]   n;
  logic [DEPTH_W-1:0]   ptr;

  // Digit stack, least significant digit at entry zero
  logic [DIGIT_W-1:0] stack [DEPTH];
  logic [DIGIT_W-1:0] rd_data;
  logic               stack_we;
  logic [DIGIT_W-1:0] stack_wdata;

  logic               accept;
  logic               out_free;
  logic               out_load;
  logic               last_digit;
  logic [DIGIT_W-1:0] rem_next;
  logic [VALUE_W-1:0] quo_next;
  chk_status_t        chk;

  // --------------------------------------------------------------------------
  // Configuration port: writes complete in the access phase, pready is tied.
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      base_size    <= RST_BASE_SIZE;
      symbols_low  <= RST_SYMBOLS_LOW;
      symbols_high <= RST_SYMBOLS_HIGH;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_BASE_SIZE:    base_size    <= pwdata[SIZE_W-1:0];
        REG_SYMBOLS_LOW:  symbols_low  <= pwdata;
        REG_SYMBOLS_HIGH: symbols_high <= pwdata;
        default:          ;
      endcase
    end
  end

  // Reads decode the full address; unaligned reads return zero.
  always_comb begin
    prdata = '0;
    if (paddr[2:0] == 3'b000) begin
      case (cfg_idx)
        REG_BASE_SIZE:    prdata = {{(REG_W-SIZE_W){1'b0}}, base_size};
        REG_SYMBOLS_LOW:  prdata = symbols_low;
        REG_SYMBOLS_HIGH: prdata = symbols_high;
        default:          prdata = '0;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Base validation runs once per value, started by the input transfer.
  // --------------------------------------------------------------------------
  itrd_base_check #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_base_check (
    .clk          (clk),
    .rst          (rst),
    .start        (accept),
    .base_size    (base_size),
    .symbols_low  (symbols_low),
    .symbols_high (symbols_high),
    .status       (chk)
  );

  // --------------------------------------------------------------------------
  // Shared divide unit: four passes give one quotient and one remainder.
  // --------------------------------------------------------------------------
  itrd_div_step u_div_step (
    .rem_in  (div_rem),
    .quo_in  (mag),
    .divisor (base_size),
    .rem_out (rem_next),
    .quo_out (quo_next)
  );

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  // The sequencer loads a new byte into the output register this cycle.
  assign out_load = out_free &&
                    ((state == S_SIGN) || (state == S_SEND) || (state == S_BAD));

  // Once the magnitude drops below the radix it is the leading digit itself.
  assign last_digit = (mag < VALUE_W'(base_size)) || (n == DEPTH_W'(DEPTH - 1));

  assign stack_we    = (state == S_DIV) &&
                       ((!div_busy && last_digit) ||
                        (div_busy && (div_cnt == DIV_CNT_W'(DIV_CYCLES - 1))));
  assign stack_wdata = div_busy ? rem_next : mag[DIGIT_W-1:0];

  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack[n] <= stack_wdata;
    end
    rd_data <= stack[ptr];
  end

  // --------------------------------------------------------------------------
  // Sequencer and output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      div_busy <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            neg   <= s_tdata[VALUE_W-1];
            mag   <= s_tdata[VALUE_W-1] ? (VALUE_W'(0) - s_tdata) : s_tdata;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (chk.done) begin
            if (chk.ok) begin
              n        <= '0;
              div_busy <= 1'b0;
              state    <= S_DIV;
            end else begin
              state <= S_BAD;
            end
          end
        end
        S_DIV: begin
          if (!div_busy) begin
            if (last_digit) begin
              ptr   <= n;
              state <= neg ? S_SIGN : S_READ;
            end else begin
              div_busy <= 1'b1;
              div_cnt  <= '0;
              div_rem  <= '0;
            end
          end else begin
            div_cnt <= div_cnt + 1'b1;
            div_rem <= rem_next;
            mag     <= quo_next;
            if (div_cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
              div_busy <= 1'b0;
              n        <= n + 1'b1;
            end
          end
        end
        S_SIGN: begin
          if (out_free) begin
            m_tvalid   <= 1'b1;
            m_tdata    <= SYM_MINUS;
            m_tlast    <= 1'b0;
            m_tuser[0] <= STATUS_OK;
            state      <= S_READ;
          end
        end
        S_READ: begin
          state <= S_SEND;
        end
        S_SEND: begin
          if (out_free) begin
            m_tvalid   <= 1'b1;
            m_tdata    <= symbol_at(symbols_low, symbols_high, rd_data);
            m_tlast    <= (ptr == '0);
            m_tuser[0] <= STATUS_OK;
            if (ptr == '0) begin
              state <= S_IDLE;
            end else begin
              ptr   <= ptr - 1'b1;
              state <= S_READ;
            end
          end
        end
        S_BAD: begin
          if (out_free) begin
            m_tvalid   <= 1'b1;
            m_tdata    <= SYM_NONE;
            m_tlast    <= 1'b1;
            m_tuser[0] <= STATUS_BAD_BASE;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/itrd_port_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrd_port_checker
// Port-level assertions for the radix digit block, bound to the top level.
// ----------------------------------------------------------------------------
`include "integer_to_radix_digits_assert.svh"

module itrd_port_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic [0:0] m_tuser
);

  // A stalled output transfer keeps its contents.
  `ITRD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "output changed while stalled")

  // A bad base report is a lone zero byte closing the run.
  `ITRD_ASSERT_SAME(a_bad_base_form, m_tvalid && m_tuser[0], m_tlast && (m_tdata == 8'h00), "malformed bad base report")

  // The block works on one value at a time.
  `ITRD_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "input taken while busy")

  // A minus sign always has digits after it.
  `ITRD_ASSERT_SAME(a_sign_not_last, m_tvalid && (m_tdata == 8'h2D), !m_tlast, "minus sign ends a run")

endmodule

bind integer_to_radix_digits itrd_port_checker u_port_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
